// ===== sv/srps_pkg.sv =====
// Shared types, codes and helpers of the run-permit safety supervisor.
// Used by srps_decide and safety_run_permit_supervisor; depends on nothing.
package srps_pkg;

	localparam int unsigned CNT_W = 32;
	localparam int unsigned FLT_W = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// event kinds
	localparam logic [2:0] CMD_RUN     = 3'd0;
	localparam logic [2:0] CMD_ILK     = 3'd1;
	localparam logic [2:0] CMD_HEALTH  = 3'd2;
	localparam logic [2:0] CMD_ACTION  = 3'd3;
	localparam logic [2:0] CMD_INSTALL = 3'd4;

	// host actions
	localparam logic [1:0] ACT_ARM    = 2'd0;
	localparam logic [1:0] ACT_DISARM = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// health levels
	localparam logic [2:0] HL_UNTRAINED = 3'd0;
	localparam logic [2:0] HL_LEARNING  = 3'd1;
	localparam logic [2:0] HL_READY     = 3'd2;
	localparam logic [2:0] HL_WARNING   = 3'd3;
	localparam logic [2:0] HL_ALARM     = 3'd4;

	// fault bits
	localparam logic [FLT_W-1:0] F_NOT_READY = 5'h01;
	localparam logic [FLT_W-1:0] F_ALARM     = 5'h02;
	localparam logic [FLT_W-1:0] F_INTERLOCK = 5'h04;
	localparam logic [FLT_W-1:0] F_NO_OUTPUT = 5'h08;
	localparam logic [FLT_W-1:0] F_OUT_FAIL  = 5'h10;

	// result codes
	localparam logic [1:0] RES_OK     = 2'd0;
	localparam logic [1:0] RES_DENIED = 2'd1;
	localparam logic [1:0] RES_OUTPUT = 2'd2;

	// reason codes
	localparam logic [3:0] RSN_NONE      = 4'd0;
	localparam logic [3:0] RSN_ARM       = 4'd1;
	localparam logic [3:0] RSN_DISARM    = 4'd2;
	localparam logic [3:0] RSN_CLEAR     = 4'd3;
	localparam logic [3:0] RSN_NOT_READY = 4'd4;
	localparam logic [3:0] RSN_ALARM     = 4'd5;
	localparam logic [3:0] RSN_INTERLOCK = 4'd6;
	localparam logic [3:0] RSN_OUT_FAIL  = 4'd7;
	localparam logic [3:0] RSN_RUN       = 4'd8;
	localparam logic [3:0] RSN_STOP      = 4'd9;
	localparam logic [3:0] RSN_WARNING   = 4'd10;
	localparam logic [3:0] RSN_RECOVERED = 4'd11;

	typedef enum logic [2:0] {
		MODE_DISABLED = 3'd0,
		MODE_ARMED    = 3'd1,
		MODE_ACTIVE   = 3'd2,
		MODE_DEGRADED = 3'd3,
		MODE_FAULT    = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       level;
		logic [2:0] health_level;
		logic [1:0] action_code;
		logic       output_accepts;
	} event_t;

	typedef struct packed {
		mode_t            mode;
		logic             supervision;
		logic             permit;
		logic [FLT_W-1:0] latched;
		logic [FLT_W-1:0] live;
		logic [CNT_W-1:0] transitions;
		logic [CNT_W-1:0] latches;
		logic [3:0]       reason;
		logic             run_request;
		logic             interlock;
		logic [2:0]       health;
		logic             output_present;
	} state_t;

	// first member in the top bits, so result_code lands at bit 0
	typedef struct packed {
		logic             drive_value;
		logic             drive_written;
		logic [3:0]       reason_code;
		logic [CNT_W-1:0] latch_episodes;
		logic [CNT_W-1:0] transitions;
		logic [FLT_W-1:0] live_mask;
		logic [FLT_W-1:0] latched_mask;
		logic             permit;
		logic             supervision_on;
		mode_t            mode;
		logic [1:0]       result_code;
	} result_t;

	localparam state_t ST_RESET = '{
		mode:           MODE_DISABLED,
		supervision:    1'b0,
		permit:         1'b0,
		latched:        '0,
		live:           F_NOT_READY | F_INTERLOCK | F_NO_OUTPUT,
		transitions:    '0,
		latches:        '0,
		reason:         RSN_NONE,
		run_request:    1'b0,
		interlock:      1'b0,
		health:         HL_UNTRAINED,
		output_present: 1'b0
	};

	function automatic logic [FLT_W-1:0] live_of(
		input logic [2:0]       health,
		input logic             interlock,
		input logic             output_present,
		input logic [FLT_W-1:0] latched
	);
		logic [FLT_W-1:0] f;
		f = '0;
		if (health == HL_UNTRAINED || health == HL_LEARNING) f = f | F_NOT_READY;
		if (health == HL_ALARM) f = f | F_ALARM;
		if (!interlock) f = f | F_INTERLOCK;
		if (!output_present) f = f | F_NO_OUTPUT;
		f = f | (latched & F_OUT_FAIL);
		return f;
	endfunction

endpackage

// ===== sv/srps_decide.sv =====
// Next-state and result logic for one supervisor event.
// Pure combinational; uses types and helpers from srps_pkg.
module srps_decide import srps_pkg::*; (
	input  state_t  st,
	input  event_t  ev,
	output state_t  st_nx,
	output result_t res
);

	state_t           nx;
	logic             wr;
	logic             wv;
	logic             acc;
	logic [1:0]       rc;
	logic             lreq;
	logic [FLT_W-1:0] lf;
	logic [3:0]       lr;
	logic [FLT_W-1:0] fresh;
	logic             gm;
	mode_t            gmode;
	logic [3:0]       greason;
	logic             tinc;
	logic             linc;
	logic             ready_ok;

	always_comb begin
		nx      = st;
		wr      = 1'b0;
		wv      = 1'b0;
		acc     = ev.output_accepts;
		rc      = RES_OK;
		lreq    = 1'b0;
		lf      = '0;
		lr      = RSN_NONE;
		fresh   = '0;
		gm      = 1'b0;
		gmode   = MODE_DISABLED;
		greason = RSN_NONE;
		tinc    = 1'b0;
		linc    = 1'b0;
		ready_ok = !st.run_request && st.health == HL_READY && st.interlock &&
			st.output_present;

		case (ev.cmd)
			CMD_RUN, CMD_ILK, CMD_HEALTH: begin
				if (ev.cmd == CMD_RUN) nx.run_request = ev.level;
				if (ev.cmd == CMD_ILK) nx.interlock = ev.level;
				if (ev.cmd == CMD_HEALTH) nx.health = ev.health_level;
				nx.live = live_of(nx.health, nx.interlock, nx.output_present, nx.latched);
				if (nx.latched != '0) begin
					// hold off and stay in fault
					if (nx.output_present) begin
						wr = 1'b1;
						if (!acc) begin
							lreq = 1'b1; lf = F_OUT_FAIL; lr = RSN_OUT_FAIL;
						end else begin
							nx.permit = 1'b0;
						end
					end
					nx.supervision = 1'b0;
					gm = 1'b1; gmode = MODE_FAULT; greason = st.reason;
				end else if (!nx.supervision) begin
					if (nx.output_present) wr = 1'b1;
					if (nx.output_present && !acc) begin
						lreq = 1'b1; lf = F_OUT_FAIL; lr = RSN_OUT_FAIL;
					end else begin
						nx.permit = 1'b0;
						gm = 1'b1; gmode = MODE_DISABLED; greason = st.reason;
					end
				end else if ((nx.live & F_INTERLOCK) != '0) begin
					lreq = 1'b1; lf = F_INTERLOCK; lr = RSN_INTERLOCK;
				end else if ((nx.live & F_NOT_READY) != '0) begin
					lreq = 1'b1; lf = F_NOT_READY; lr = RSN_NOT_READY;
				end else if ((nx.live & F_ALARM) != '0) begin
					lreq = 1'b1; lf = F_ALARM; lr = RSN_ALARM;
				end else if (nx.output_present) begin
					wr = 1'b1;
					wv = nx.run_request;
					if (!acc) begin
						lreq = 1'b1; lf = F_OUT_FAIL; lr = RSN_OUT_FAIL;
					end else begin
						nx.permit = nx.run_request;
						gm = 1'b1;
						if (!nx.run_request) begin
							gmode = MODE_ARMED; greason = RSN_STOP;
						end else if (nx.health == HL_WARNING) begin
							gmode = MODE_DEGRADED; greason = RSN_WARNING;
						end else begin
							gmode = MODE_ACTIVE;
							greason = (st.mode == MODE_DEGRADED) ? RSN_RECOVERED : RSN_RUN;
						end
					end
				end
			end
			CMD_ACTION: begin
				case (ev.action_code)
					ACT_DISARM: begin
						nx.supervision = 1'b0;
						if (nx.output_present) wr = 1'b1;
						if (nx.output_present && !acc) begin
							lreq = 1'b1; lf = F_OUT_FAIL; lr = RSN_OUT_FAIL;
							rc = RES_OUTPUT;
						end else begin
							nx.permit = 1'b0;
							gm = 1'b1;
							gmode = (nx.latched != '0) ? MODE_FAULT : MODE_DISABLED;
							greason = RSN_DISARM;
							nx.live = live_of(nx.health, nx.interlock, nx.output_present,
								nx.latched);
						end
					end
					ACT_CLEAR: begin
						if (st.supervision || !ready_ok) begin
							rc = RES_DENIED;
						end else begin
							wr = 1'b1;
							if (!acc) begin
								lreq = 1'b1; lf = F_OUT_FAIL; lr = RSN_OUT_FAIL;
								rc = RES_OUTPUT;
							end else begin
								nx.latched = '0;
								nx.permit = 1'b0;
								gm = 1'b1; gmode = MODE_DISABLED; greason = RSN_CLEAR;
								nx.live = live_of(nx.health, nx.interlock, nx.output_present,
									'0);
							end
						end
					end
					ACT_ARM: begin
						if (st.latched != '0 || !ready_ok) begin
							rc = RES_DENIED;
						end else begin
							wr = 1'b1;
							if (!acc) begin
								lreq = 1'b1; lf = F_OUT_FAIL; lr = RSN_OUT_FAIL;
								rc = RES_OUTPUT;
							end else begin
								nx.permit = 1'b0;
								nx.supervision = 1'b1;
								gm = 1'b1; gmode = MODE_ARMED; greason = RSN_ARM;
								nx.live = live_of(nx.health, nx.interlock, nx.output_present,
									nx.latched);
							end
						end
					end
					default: rc = RES_DENIED;
				endcase
			end
			CMD_INSTALL: begin
				nx.output_present = 1'b1;
				wr = 1'b1;
				if (!acc) begin
					lreq = 1'b1; lf = F_OUT_FAIL; lr = RSN_OUT_FAIL;
					rc = RES_OUTPUT;
				end else begin
					nx.permit = 1'b0;
					nx.live = live_of(nx.health, nx.interlock, 1'b1, nx.latched);
				end
			end
			default: rc = RES_DENIED;
		endcase

		// fault latch always ends the event; fresh bits are counted before the
		// safe-off write can add an output failure
		if (lreq) begin
			fresh = lf & ~nx.latched;
			nx.latched = nx.latched | lf;
			linc = (fresh != '0);
			nx.supervision = 1'b0;
			nx.permit = 1'b0;
			if (nx.output_present) begin
				wr = 1'b1;
				wv = 1'b0;
				if (!acc) nx.latched = nx.latched | F_OUT_FAIL;
			end
			gm = 1'b1; gmode = MODE_FAULT; greason = lr;
			nx.live = live_of(nx.health, nx.interlock, nx.output_present, nx.latched);
		end

		if (gm && nx.mode != gmode) begin
			nx.mode = gmode;
			nx.reason = greason;
			tinc = 1'b1;
		end

		if (tinc && st.transitions != CNT_MAX) nx.transitions = st.transitions + 1'b1;
		if (linc && st.latches != CNT_MAX) nx.latches = st.latches + 1'b1;
	end

	assign st_nx = nx;

	always_comb begin
		res.drive_value    = wv;
		res.drive_written  = wr;
		res.reason_code    = nx.reason;
		res.latch_episodes = nx.latches;
		res.transitions    = nx.transitions;
		res.live_mask      = nx.live;
		res.latched_mask   = nx.latched;
		res.permit         = nx.permit;
		res.supervision_on = nx.supervision;
		res.mode           = nx.mode;
		res.result_code    = rc;
	end

endmodule

// ===== sv/safety_run_permit_supervisor.sv =====
// Run-permit safety supervisor: one event in per cycle unless stalled by the output,
// one status beat out per event. Event register, srps_decide, supervisor state and a
// status output register. Depends on srps_pkg and srps_decide.

// Each input beat is one event (kind in s_tuser): set run request, set interlock,
// health update, host action or output-driver install. The supervisor recomputes its
// fault masks and mode and returns one status beat per event carrying the result
// code, mode, permit, fault masks, saturating counters, last reason and the driver
// write made for that event. An event goes from input to output through the event
// register, then the status register; the state update sits between them, so a new
// event is taken every cycle while the output side keeps up. While a finished
// status beat waits to be taken, the input accepts one more event into the event
// register and then holds off until the status beat leaves.
module safety_run_permit_supervisor import srps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] level, [3:1] health_level, [5:4] action_code, [6] output_accepts, [7] zero
	input  logic [7:0]  s_tdata,
	// [2:0] cmd
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] result_code, [4:2] mode, [5] supervision_on, [6] permit,
	// [11:7] latched_mask, [16:12] live_mask, [48:17] transitions,
	// [80:49] latch_episodes, [84:81] reason_code, [85] drive_written,
	// [86] drive_value, [87] zero
	output logic [87:0] m_tdata
);

	logic    vld_s1;
	event_t  ev_s1;
	logic    vld_s2;
	result_t res_s2;
	state_t  st_q;
	state_t  st_nx;
	result_t res_nx;
	logic    adv;

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ev_s1.cmd            <= s_tuser;
			ev_s1.level          <= s_tdata[0];
			ev_s1.health_level   <= s_tdata[3:1];
			ev_s1.action_code    <= s_tdata[5:4];
			ev_s1.output_accepts <= s_tdata[6];
		end
	end

	srps_decide u_decide (
		.st    (st_q),
		.ev    (ev_s1),
		.st_nx (st_nx),
		.res   (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_RESET;
			vld_s2 <= 1'b0;
		end else begin
			if (adv) begin
				st_q   <= st_nx;
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// hold the status beat until taken
	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res_nx;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {1'b0, res_s2};

`ifndef SYNTH
	a_sup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.supervision |-> (st_q.latched == '0))
		else $error("supervision armed with latched faults");

	a_fault_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.latched != '0) == (st_q.mode == MODE_FAULT))
		else $error("fault mode and latched mask disagree");

	a_permit_sup: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.permit |-> st_q.supervision)
		else $error("permit granted without supervision");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (st_q.transitions >= $past(st_q.transitions)) &&
			(st_q.latches >= $past(st_q.latches)))
		else $error("saturating counter went backwards");
`endif

endmodule
